/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/birs_pkg.sv */
package birs_pkg;
   localparam int MAX_IN_WIDTH = 1024;
   localparam int COL_W = $clog2(MAX_IN_WIDTH);
   localparam int ADDR_W = COL_W + 1;

   localparam logic [1:0] ST_PUSH_OK = 2'd0;
   localparam logic [1:0] ST_PUSH_REFUSED = 2'd1;
   localparam logic [1:0] ST_PIXEL = 2'd2;
   localparam logic [1:0] ST_NOT_READY = 2'd3;

   localparam logic [2:0] REG_IN_WIDTH = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_OUT_WIDTH = 3'd2;
   localparam logic [2:0] REG_OUT_HEIGHT = 3'd3;
   localparam logic [2:0] REG_SCALE_H = 3'd4;
   localparam logic [2:0] REG_SCALE_V = 3'd5;

   // Neighbor pair and blend fraction of one clamped sample position.
   typedef struct packed {
      logic [11:0] lo;
      logic [11:0] hi;
      logic [15:0] frac;
   } locate_type;

   // Clamp a Q20.16 position to (dim-1) and split it; pos is already multiplied.
   function automatic locate_type locate_pos(input logic [35:0] pos, input logic [11:0] dim);
      logic [35:0] lim;
      logic [35:0] p;
      locate_type r;
      lim = {8'd0, dim - 12'd1, 16'd0};
      p = (pos > lim) ? lim : pos;
      r.lo = p[27:16];
      r.frac = p[15:0];
      r.hi = (r.lo + 12'd1 > dim - 12'd1) ? dim - 12'd1 : r.lo + 12'd1;
      return r;
   endfunction
endpackage

/* rtl/birs_line_store.sv */
module birs_line_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [birs_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic [birs_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                   rd_data
);
   import birs_pkg::*;

   logic [7:0] mem [2*MAX_IN_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/bilinear_image_resize_stream.sv */
// Bilinear image resizer with a two-row line store. Push items (command 0)
// write one raster-order input pixel; pull items (command 1) return the next
// output pixel or "no pixel ready". Every item gives exactly one result item.
// For a push, a refused push and a not-ready pull the result item is
// registered in S_RD1, after the S_LOC and S_DEC states; a delivered pixel
// takes longer, because the four neighbors are fetched one at a time
// through the single read port of the line store and the products are formed
// in the registered S_MUL and S_SUM states before S_OUT. One item is in work
// at a time, and the next item can be accepted in the same cycle that the
// result appears, so long as rsp_stall is low. While a result waits on
// rsp_stall no new item is accepted.
// The line store has no reset; its contents are defined once rows are pushed.
`include "assert_macros.svh"
module bilinear_image_resize_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_pixel_out,
   output logic        rsp_row_end,
   output logic        rsp_frame_end
);
   import birs_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOC = 4'd1;   // multiply positions
   localparam logic [3:0] S_DEC = 4'd2;   // clamp positions, split neighbors
   localparam logic [3:0] S_RD1 = 4'd3;
   localparam logic [3:0] S_RD2 = 4'd4;
   localparam logic [3:0] S_RD3 = 4'd5;
   localparam logic [3:0] S_RD4 = 4'd6;
   localparam logic [3:0] S_MUL = 4'd7;
   localparam logic [3:0] S_SUM = 4'd8;
   localparam logic [3:0] S_OUT = 4'd9;

   // Configuration registers.
   logic [10:0] in_width_ff;
   logic [11:0] in_height_ff, out_width_ff, out_height_ff;
   logic [23:0] scale_h_ff, scale_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff <= 11'd1;
         in_height_ff <= 12'd1;
         out_width_ff <= 12'd1;
         out_height_ff <= 12'd1;
         scale_h_ff <= 24'h010000;
         scale_v_ff <= 24'h010000;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IN_WIDTH: in_width_ff <= csr_data[10:0];
            REG_IN_HEIGHT: in_height_ff <= csr_data[11:0];
            REG_OUT_WIDTH: out_width_ff <= csr_data[11:0];
            REG_OUT_HEIGHT: out_height_ff <= csr_data[11:0];
            REG_SCALE_H: scale_h_ff <= csr_data;
            REG_SCALE_V: scale_v_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective dimensions: zero acts as one, width capped at the store depth.
   logic [11:0] iw, ih, ow, oh;
   always_comb begin
      if (in_width_ff == 11'd0) iw = 12'd1;
      else if (in_width_ff > 11'(MAX_IN_WIDTH)) iw = 12'(MAX_IN_WIDTH);
      else iw = {1'b0, in_width_ff};
      ih = (in_height_ff == 12'd0) ? 12'd1 : in_height_ff;
      ow = (out_width_ff == 12'd0) ? 12'd1 : out_width_ff;
      oh = (out_height_ff == 12'd0) ? 12'd1 : out_height_ff;
   end

   // Frame counters.
   logic [11:0] in_column_ff, in_column_in;
   logic [11:0] rows_loaded_ff, rows_loaded_in;
   logic [11:0] out_row_ff, out_row_in;
   logic [11:0] out_column_ff, out_column_in;

   logic [3:0] state_ff, state_in;
   logic       cmd_ff, cmd_in;
   logic [7:0] pix_ff, pix_in;
   logic [35:0] posv_ff, posv_in, posu_ff, posu_in;
   locate_type lv_ff, lv_in, lu_ff, lu_in;
   logic [7:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in;
   logic [16:0] wx0_ff, wx0_in; // 65536 - du, which needs 17 bits
   logic [16:0] wa_ff, wa_in, wb_ff, wb_in;
   logic [24:0] m0_ff, m0_in, m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic [49:0] acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  pixel_ff, pixel_in;
   logic        rend_ff, rend_in, fend_ff, fend_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        rd_data;

   birs_line_store u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(pix_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   wire req_take = req_valid && !req_stall;
   wire rsp_take = rsp_valid_ff && !rsp_stall;

   // Push refusal and pull readiness, evaluated in S_RD1, and the row and frame end flags, used in S_OUT.
   logic refuse, not_ready, rend, fend;
   always_comb begin
      refuse = (rows_loaded_ff >= ih) ||
               ((rows_loaded_ff >= 12'd2) && (lv_ff.lo <= rows_loaded_ff - 12'd2));
      not_ready = lv_ff.hi >= rows_loaded_ff;
      rend = ({1'b0, out_column_ff} + 13'd1) >= {1'b0, ow};
      fend = rend && (({1'b0, out_row_ff} + 13'd1) >= {1'b0, oh});
   end

   function automatic logic [ADDR_W-1:0] addr_of(input logic [11:0] row, input logic [11:0] col);
      return {row[0], col[COL_W-1:0]};
   endfunction

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      pix_in = pix_ff;
      posv_in = posv_ff;
      posu_in = posu_ff;
      lv_in = lv_ff;
      lu_in = lu_ff;
      p00_in = p00_ff;
      p01_in = p01_ff;
      p10_in = p10_ff;
      wx0_in = wx0_ff;
      wa_in = wa_ff;
      wb_in = wb_ff;
      m0_in = m0_ff;
      m1_in = m1_ff;
      m2_in = m2_ff;
      m3_in = m3_ff;
      acc_in = acc_ff;
      in_column_in = in_column_ff;
      rows_loaded_in = rows_loaded_ff;
      out_row_in = out_row_ff;
      out_column_in = out_column_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      status_in = status_ff;
      pixel_in = pixel_ff;
      rend_in = rend_ff;
      fend_in = fend_ff;
      wr_en = 1'b0;
      wr_addr = addr_of(rows_loaded_ff, in_column_ff);
      rd_addr = addr_of(lv_ff.lo, lu_ff.lo);

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in = req_command;
               pix_in = req_pixel_in;
               state_in = S_LOC;
            end
         end
         S_LOC: begin
            posv_in = 36'(scale_v_ff * out_row_ff);
            posu_in = 36'(scale_h_ff * out_column_ff);
            state_in = S_DEC;
         end
         S_DEC: begin
            lv_in = locate_pos(posv_ff, ih);
            lu_in = locate_pos(posu_ff, iw);
            state_in = S_RD1;
         end
         S_RD1: begin
            // Decision point; the first neighbor read is issued here.
            rd_addr = addr_of(lv_ff.lo, lu_ff.lo);
            if (!cmd_ff) begin
               rend_in = 1'b0;
               fend_in = 1'b0;
               pixel_in = 8'd0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               if (refuse) begin
                  status_in = ST_PUSH_REFUSED;
               end else begin
                  status_in = ST_PUSH_OK;
                  wr_en = 1'b1;
                  if (in_column_ff + 12'd1 >= iw) begin
                     in_column_in = 12'd0;
                     rows_loaded_in = rows_loaded_ff + 12'd1;
                  end else begin
                     in_column_in = in_column_ff + 12'd1;
                  end
               end
            end else if (not_ready) begin
               status_in = ST_NOT_READY;
               pixel_in = 8'd0;
               rend_in = 1'b0;
               fend_in = 1'b0;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_RD2;
            end
         end
         S_RD2: begin
            p00_in = rd_data;
            rd_addr = addr_of(lv_ff.lo, lu_ff.hi);
            wx0_in = 17'h10000 - {1'b0, lu_ff.frac};
            state_in = S_RD3;
         end
         S_RD3: begin
            p01_in = rd_data;
            rd_addr = addr_of(lv_ff.hi, lu_ff.lo);
            wa_in = 17'h10000 - {1'b0, lv_ff.frac};
            state_in = S_RD4;
         end
         S_RD4: begin
            p10_in = rd_data;
            rd_addr = addr_of(lv_ff.hi, lu_ff.hi);
            state_in = S_MUL;
         end
         S_MUL: begin
            // Pixel times horizontal weight; the last neighbor comes straight
            // from the read port.
            m0_in = 25'(p00_ff * wx0_ff);
            m1_in = 25'(p01_ff * {1'b0, lu_ff.frac});
            m2_in = 25'(p10_ff * wx0_ff);
            m3_in = 25'(rd_data * {1'b0, lu_ff.frac});
            wb_in = {1'b0, lv_ff.frac};
            state_in = S_SUM;
         end
         S_SUM: begin
            // Row sums times vertical weight.
            acc_in = 50'((26'(m0_ff) + 26'(m1_ff)) * wa_ff)
                   + 50'((26'(m2_ff) + 26'(m3_ff)) * wb_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            status_in = ST_PIXEL;
            pixel_in = (acc_ff[49:32] > 18'd255) ? 8'd255 : acc_ff[39:32];
            rend_in = rend;
            fend_in = fend;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
            if (fend) begin
               in_column_in = 12'd0;
               rows_loaded_in = 12'd0;
               out_row_in = 12'd0;
               out_column_in = 12'd0;
            end else if (rend) begin
               out_column_in = 12'd0;
               out_row_in = out_row_ff + 12'd1;
            end else begin
               out_column_in = out_column_ff + 12'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         in_column_ff <= 12'd0;
         rows_loaded_ff <= 12'd0;
         out_row_ff <= 12'd0;
         out_column_ff <= 12'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         in_column_ff <= in_column_in;
         rows_loaded_ff <= rows_loaded_in;
         out_row_ff <= out_row_in;
         out_column_ff <= out_column_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      pix_ff <= pix_in;
      posv_ff <= posv_in;
      posu_ff <= posu_in;
      lv_ff <= lv_in;
      lu_ff <= lu_in;
      p00_ff <= p00_in;
      p01_ff <= p01_in;
      p10_ff <= p10_in;
      wx0_ff <= wx0_in;
      wa_ff <= wa_in;
      wb_ff <= wb_in;
      m0_ff <= m0_in;
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      m3_ff <= m3_in;
      acc_ff <= acc_in;
      status_ff <= status_in;
      pixel_ff <= pixel_in;
      rend_ff <= rend_in;
      fend_ff <= fend_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_pixel_out = pixel_ff;
   assign rsp_row_end = rend_ff;
   assign rsp_frame_end = fend_ff;

   // A frame end is always also a row end, and both only with a pixel.
   `ASSERT_CLK(a_fend_rend, !rsp_valid || !rsp_frame_end || rsp_row_end, "frame_end without row_end")
   `ASSERT_CLK(a_end_pixel, !rsp_valid || !rsp_row_end || rsp_status == ST_PIXEL, "row_end w/o pixel")
   // Only one item is in work: no intake outside the idle state.
   `ASSERT_NEXT(a_one_item, req_valid && !req_stall, state_ff == S_LOC, "item not started")
endmodule
